/* hw/rtl/sli_pkg.sv */
// Shared types and constants for the sorted list insert/remove block.
// Used by sli_ctrl, sli_datapath and sorted_list_insert_remove.
package sli_pkg;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned COUNT_W = 5;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_DUMP   = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_EMPTY    = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_UPDATE,
    S_DUMP
  } ctrl_state_e;

  typedef struct packed {
    op_e                        op;
    logic signed [VALUE_W-1:0]  value;
  } sli_in_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0]  item;
    logic                       last;
    logic [COUNT_W-1:0]         count;
    status_e                    status;
  } sli_out_t;

  // controller -> datapath
  typedef struct packed {
    logic load;       // latch the accepted item
    logic exec;       // apply insert/remove, or report an empty dump
    logic dump_step;  // emit the head entry and rotate the store
  } sli_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic count_zero;
    logic dump_last;
  } sli_sts_t;

endpackage

/* hw/rtl/sli_ctrl.sv */
// Controller state machine for the sorted list block.
// Depends on sli_pkg; drives sli_datapath through sli_cmd_t.
module sli_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  input  sli_pkg::op_e     op_i,
  input  sli_pkg::sli_sts_t sts_i,
  output sli_pkg::sli_cmd_t cmd_o,
  output logic             busy
);
  import sli_pkg::*;

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          unique case (op_i)
            OP_INSERT, OP_REMOVE: state_d = S_UPDATE;
            OP_DUMP:              state_d = sts_i.count_zero ? S_UPDATE : S_DUMP;
            default:              state_d = S_IDLE;
          endcase
        end
      end
      S_UPDATE: state_d = S_IDLE;
      S_DUMP: begin
        if (sts_i.dump_last) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o = '0;
    busy  = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        busy       = 1'b0;
        cmd_o.load = start;
      end
      S_UPDATE: cmd_o.exec      = 1'b1;
      S_DUMP:   cmd_o.dump_step = 1'b1;
      default:  busy            = 1'b1;
    endcase
  end

endmodule

/* hw/rtl/sli_datapath.sv */
// Datapath for the sorted list block: the store cells, count and result register.
// Depends on sli_pkg; sequenced by sli_ctrl.
module sli_datapath #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sli_pkg::sli_cmd_t cmd_i,
  input  sli_pkg::sli_in_t  in_i,
  output sli_pkg::sli_sts_t sts_o,
  output sli_pkg::sli_out_t out_o,
  output logic              valid_o
);
  import sli_pkg::*;

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  op_e                       op_q;
  logic signed [VALUE_W-1:0] value_q;
  logic [CNT_W-1:0]          count_q, count_d;
  logic [CNT_W-1:0]          left_q, left_d;
  logic signed [VALUE_W-1:0] store_q   [CAPACITY];
  logic signed [VALUE_W-1:0] ins_d     [CAPACITY];
  logic signed [VALUE_W-1:0] rem_d     [CAPACITY];
  logic signed [VALUE_W-1:0] rot_d     [CAPACITY];
  logic [CAPACITY-1:0]       lt, eq;
  logic                      full, found;
  sli_out_t                  out_q, out_d;
  logic                      valid_q;

  assign full  = (count_q == CNT_W'(CAPACITY));
  assign found = |eq;

  // One cell per entry: compare against the request and pick the neighbor to take.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic in_use;
    assign in_use = (count_q > CNT_W'(g));
    assign lt[g]  = in_use && (store_q[g] < value_q);
    assign eq[g]  = in_use && (store_q[g] == value_q);

    if (g == 0) begin : g_head
      assign ins_d[g] = lt[g] ? store_q[g] : value_q;
    end else begin : g_body
      assign ins_d[g] = lt[g] ? store_q[g] : (lt[g-1] ? value_q : store_q[g-1]);
    end

    if (g == CAPACITY - 1) begin : g_tail
      assign rem_d[g] = store_q[g];
      assign rot_d[g] = store_q[0];
    end else begin : g_mid
      assign rem_d[g] = lt[g] ? store_q[g] : store_q[g+1];
      assign rot_d[g] = (count_q == CNT_W'(g + 1)) ? store_q[0] : store_q[g+1];
    end
  end

  always_comb begin
    count_d = count_q;
    left_d  = left_q;
    out_d   = out_q;
    if (cmd_i.load) begin
      left_d = count_q;
    end
    if (cmd_i.exec) begin
      out_d.item   = '0;
      out_d.last   = 1'b1;
      out_d.status = ST_OK;
      unique case (op_q)
        OP_INSERT: begin
          if (full) out_d.status = ST_FULL;
          else      count_d      = count_q + 1'b1;
        end
        OP_REMOVE: begin
          if (found) count_d      = count_q - 1'b1;
          else       out_d.status = ST_NOTFOUND;
        end
        default: out_d.status = ST_EMPTY;
      endcase
      out_d.count = COUNT_W'(count_d);
    end
    if (cmd_i.dump_step) begin
      out_d.item   = store_q[0];
      out_d.last   = (left_q == CNT_W'(1));
      out_d.count  = COUNT_W'(count_q);
      out_d.status = ST_OK;
      left_d       = left_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      left_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      left_q  <= left_d;
      valid_q <= cmd_i.exec || cmd_i.dump_step;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (cmd_i.load) begin
      op_q    <= in_i.op;
      value_q <= in_i.value;
    end
    for (int i = 0; i < CAPACITY; i++) begin
      if (cmd_i.exec && op_q == OP_INSERT && !full) begin
        store_q[i] <= ins_d[i];
      end else if (cmd_i.exec && op_q == OP_REMOVE && found) begin
        store_q[i] <= rem_d[i];
      end else if (cmd_i.dump_step) begin
        store_q[i] <= rot_d[i];
      end
    end
  end

  assign sts_o.count_zero = (count_q == '0);
  assign sts_o.dump_last  = (left_q == CNT_W'(1));
  assign out_o            = out_q;
  assign valid_o          = valid_q;

endmodule

/* hw/rtl/sorted_list_insert_remove.sv */
// Sorted list of signed 32-bit values with insert, remove and in-order dump.
// Insert/remove: busy in the update state after start is taken, result strobe in
// the next cycle; no new item is taken until the update is done. Dump of n
// values: n results on consecutive cycles via the dump state and the result
// register, busy until the last result. Result rate is set by the cell update
// and by a one-entry-per-cycle rotation of the store during dump. The receiver
// cannot stall. Async reset empties the list (count zero) but keeps entries.
module sorted_list_insert_remove #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  sli_pkg::sli_in_t  in_i,
  output logic              busy,
  output sli_pkg::sli_out_t out_o,
  output logic              valid_o
);
  import sli_pkg::*;

  sli_cmd_t cmd;
  sli_sts_t sts;

  // Controller: sequences load, update and the dump walk.
  sli_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .op_i   (in_i.op),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy   (busy)
  );

  // Datapath: one compare/shift cell per entry, plus the result register.
  sli_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd),
    .in_i    (in_i),
    .sts_o   (sts),
    .out_o   (out_o),
    .valid_o (valid_o)
  );

  // Insert and remove always answer with a final result after the update state.
  a_update_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && (in_i.op == OP_INSERT || in_i.op == OP_REMOVE)
      |-> ##2 (valid_o && out_o.last))
    else $error("insert/remove result missing");

  // The final result of an item frees the block; earlier dump results keep it busy.
  a_last_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (out_o.last == !busy))
    else $error("busy does not match last result");

  // Error and empty statuses come only as a single, final result.
  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && out_o.status != ST_OK |-> out_o.last)
    else $error("non-ok status on a non-final result");

  // An empty dump reports a zero count.
  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && out_o.status == ST_EMPTY |-> out_o.count == '0)
    else $error("empty status with nonzero count");

endmodule
